@@ src/p16c_pkg.sv @@
`timescale 1ns / 1ps

package p16c_pkg;

    localparam int unsigned W = 16;

    typedef logic [W-1:0] t_word;

    localparam t_word P16_NAR   = 16'h8000;
    localparam t_word P16_ZERO  = 16'h0000;
    localparam t_word P16_ONE   = 16'h4000;
    localparam t_word P16_TWO   = 16'h5000;
    localparam t_word P16_THREE = 16'h5800;
    localparam t_word P16_BIG   = 16'h7C00;

endpackage

@@ src/posit16_ceiling_core.sv @@
`timescale 1ns / 1ps

// Channel   Ports                      Direction  Handshake
// command   start, busy, i_operand     in         taken when start && !busy
// result    o_strobe, o_rounded        out        valid for one cycle with o_strobe
//
// One word per cycle, fully pipelined: operand register, rounding logic,
// result register. A command's word passes the operand register, then the result register.
// busy is always low; the receiver cannot stall, so no back pressure exists.
// Synchronous active-low reset clears the valid flags only.

module posit16_ceiling_core
    import p16c_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_word i_operand,
    output logic  o_strobe,
    output t_word o_rounded
);

    logic  r_in_vld;
    logic  r_out_vld;
    t_word r_op;
    t_word r_res;
    t_word n_res;

    assign busy = 1'b0;

    p16c_round u_round (
        .i_word   (r_op),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op <= i_operand;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_strobe  = r_out_vld;
    assign o_rounded = r_res;

endmodule

@@ src/p16c_round.sv @@
`timescale 1ns / 1ps

module p16c_round
    import p16c_pkg::*;
(
    input  t_word i_word,
    output t_word o_result
);

    logic       neg;
    t_word      mag;
    t_word      res;
    t_word      trunc;
    t_word      lsb;
    t_word      fmask;
    logic [1:0] k;
    logic       e;
    logic [3:0] pos;

    assign neg = i_word[15];
    assign mag = neg ? (~i_word + 16'd1) : i_word;

    // regime run after bit 14; magnitude below 0x7C00 keeps it at three ones or fewer
    always_comb begin
        priority if (!mag[13]) begin
            k = 2'd0;
            e = mag[12];
        end else if (!mag[12]) begin
            k = 2'd1;
            e = mag[11];
        end else if (!mag[11]) begin
            k = 2'd2;
            e = mag[10];
        end else begin
            k = 2'd3;
            e = mag[9];
        end
    end

    // integer LSB sits at bit 12 - 3k - e
    assign pos   = 4'd12 - ({2'b00, k} + {1'b0, k, 1'b0}) - {3'b000, e};
    assign lsb   = t_word'(16'd1 << pos);
    assign fmask = lsb - 16'd1;
    assign trunc = mag & ~fmask;

    always_comb begin
        priority if (mag <= P16_ONE) begin
            res = (neg && mag != P16_ONE) ? P16_ZERO : P16_ONE;
        end else if (mag <= P16_TWO) begin
            res = (neg && mag != P16_TWO) ? P16_ONE : P16_TWO;
        end else if (mag <= P16_THREE) begin
            res = (neg && mag != P16_THREE) ? P16_TWO : P16_THREE;
        end else if (!neg && (mag & fmask) != P16_ZERO) begin
            res = trunc + lsb;
        end else begin
            res = trunc;
        end
    end

    always_comb begin
        priority if (i_word == P16_NAR || i_word == P16_ZERO || mag >= P16_BIG) begin
            o_result = i_word;
        end else if (neg) begin
            o_result = ~res + 16'd1;
        end else begin
            o_result = res;
        end
    end

endmodule
